/* hw/rtl/cq_pkg.sv */
package cq_pkg;

    localparam int DEFAULT_DEPTH = 8;
    localparam int WORD_W = 32;

    typedef logic [1:0] t_opcode;
    typedef logic [1:0] t_status;
    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_opcode OP_ENQ  = 2'd0;
    localparam t_opcode OP_DEQ  = 2'd1;
    localparam t_opcode OP_PEEK = 2'd2;
    localparam t_opcode OP_NOP  = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

endpackage

/* hw/rtl/cq_in_if.sv */
interface cq_in_if;
    import cq_pkg::*;

    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_word   push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink (input valid, input opcode, input push_value, output ready);
endinterface

/* hw/rtl/cq_out_if.sv */
interface cq_out_if;
    import cq_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_word   head_value;
    t_word   tail_value;
    logic    now_empty;
    logic    now_full;

    modport source (
        output valid, output status, output head_value, output tail_value,
        output now_empty, output now_full, input ready
    );
    modport sink (
        input valid, input status, input head_value, input tail_value,
        input now_empty, input now_full, output ready
    );
endinterface

/* hw/rtl/circular_queue.sv */
// Ring-buffer queue of DEPTH signed 32-bit words.
// The input channel carries one word per operation: an opcode (enqueue,
// dequeue, peek or no operation) and the value to store on enqueue.
// The output channel returns exactly one word per operation: a status
// (ok, full, empty), the dequeued or peeked head word, the peeked tail word,
// and the empty and full flags after the operation.
// Enqueue and no-operation words, and dequeue or peek words that find the
// queue empty, need no memory read; while the receiver keeps up a new word
// is taken every cycle, and the result is in the output register in the
// cycle after acceptance. Other dequeue and peek words read the slot memory
// through a registered read port, so the result passes the read register and
// then the output register; the input is not ready during the read
// cycle.
// The output register holds a result until the receiver takes it; while it
// is stalled with a result pending, no new word is accepted.
// Reset clears the pointers and marks the queue empty; the slot memory is
// not cleared, since only occupied slots are ever returned.
module circular_queue #(
    parameter int DEPTH = cq_pkg::DEFAULT_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cq_in_if.sink    i_in,
    cq_out_if.source o_out
);
    import cq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] i);
        if (i == IW'(DEPTH - 1)) begin
            return '0;
        end
        return i + 1'b1;
    endfunction

    t_word r_mem [DEPTH];

    logic [IW-1:0] r_head;
    logic [IW-1:0] r_tail;
    logic          r_empty;
    logic          r_busy;
    logic          r_pend_peek;
    t_word         r_rd_head;
    t_word         r_rd_tail;

    logic          r_out_valid;
    t_status       r_out_status;
    t_word         r_out_head;
    t_word         r_out_tail;
    logic          r_out_empty;
    logic          r_out_full;

    logic [IW-1:0] n_head;
    logic [IW-1:0] n_tail;
    logic          n_empty;
    logic          n_full;
    t_status       n_status;
    logic          need_read;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          cur_full;
    logic          in_ready;
    logic          accept;

    assign cur_full = !r_empty && (wrap_next(r_tail) == r_head);
    assign in_ready = !r_busy && (!r_out_valid || o_out.ready);
    assign accept   = i_in.valid && in_ready;

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        n_status  = ST_OK;
        need_read = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_tail;
        unique case (i_in.opcode)
            OP_ENQ: begin
                if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    wr_en   = 1'b1;
                    wr_addr = '0;
                end else if (cur_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_tail  = wrap_next(r_tail);
                    wr_en   = 1'b1;
                    wr_addr = wrap_next(r_tail);
                end
            end
            OP_DEQ: begin
                if (r_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    need_read = 1'b1;
                    if (r_head == r_tail) begin
                        n_empty = 1'b1;
                    end else begin
                        n_head = wrap_next(r_head);
                    end
                end
            end
            OP_PEEK: begin
                if (r_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    need_read = 1'b1;
                end
            end
            OP_NOP: begin
            end
        endcase
        n_full = !n_empty && (wrap_next(n_tail) == n_head);
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_mem[wr_addr] <= i_in.push_value;
        end
        r_rd_head <= r_mem[r_head];
        r_rd_tail <= r_mem[r_tail];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_empty <= n_empty;
            end
            if (r_busy) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (accept) begin
                r_busy      <= need_read;
                r_out_valid <= !need_read;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_out_head <= r_rd_head;
            r_out_tail <= r_pend_peek ? r_rd_tail : '0;
        end else if (accept) begin
            r_pend_peek  <= (i_in.opcode == OP_PEEK);
            r_out_status <= n_status;
            r_out_head   <= '0;
            r_out_tail   <= '0;
            r_out_empty  <= n_empty;
            r_out_full   <= n_full;
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.head_value = r_out_head;
    assign o_out.tail_value = r_out_tail;
    assign o_out.now_empty  = r_out_empty;
    assign o_out.now_full   = r_out_full;

`ifndef SYNTHESIS
    a_busy_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_out_valid)
        else $error("read cycle started while a result was still pending");

    a_busy_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (r_out_valid && !r_busy))
        else $error("memory read did not produce a result");

    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_empty && (i_in.opcode == OP_DEQ))
            |=> (r_out_valid && (r_out_status == ST_EMPTY) && r_out_empty))
        else $error("dequeue on empty queue not reported");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_empty && r_out_full))
        else $error("queue reported both empty and full");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import cq_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int RANDOM_ITEMS = 1725;
    localparam int HOLD_CYCLES = 160;
    localparam int HOLD_AFTER = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        t_status status;
        t_word   head_value;
        t_word   tail_value;
        logic    now_empty;
        logic    now_full;
    } queue_result_t;

    typedef struct {
        t_opcode       op;
        t_word         value;
        bit            typed;
        queue_result_t want;
    } stim_row_t;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

    localparam queue_result_t NO_RES = '0;

    logic i_clk;
    logic i_rst_n;
    logic calm = 1'b0;
    logic hold_out = 1'b0;

    cq_in_if  in_ch ();
    cq_out_if out_ch ();

    circular_queue #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the ring buffer.
    t_word            ring_slots [DEPTH];
    logic [IDX_W-1:0] ring_head = '0;
    logic [IDX_W-1:0] ring_tail = '0;
    logic             ring_empty = 1'b1;

    queue_result_t pending_results [$];
    int errors = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int full_drops = 0;
    int empty_reads = 0;
    int op_counts [4] = '{0, 0, 0, 0};

    stim_row_t directed_rows [25] = '{
        '{OP_DEQ,  32'sh00000000, 1'b1, '{ST_EMPTY, 32'sh0, 32'sh0, 1'b1, 1'b0}},
        '{OP_PEEK, 32'sh00000000, 1'b1, '{ST_EMPTY, 32'sh0, 32'sh0, 1'b1, 1'b0}},
        '{OP_NOP,  32'sh12345678, 1'b1, '{ST_OK, 32'sh0, 32'sh0, 1'b1, 1'b0}},
        '{OP_ENQ,  32'sh80000000, 1'b1, '{ST_OK, 32'sh0, 32'sh0, 1'b0, 1'b0}},
        '{OP_PEEK, 32'sh00000000, 1'b1,
          '{ST_OK, 32'sh80000000, 32'sh80000000, 1'b0, 1'b0}},
        '{OP_ENQ,  32'sh7fffffff, 1'b0, NO_RES},
        '{OP_ENQ,  32'shffffffff, 1'b0, NO_RES},
        '{OP_ENQ,  32'sh00000000, 1'b0, NO_RES},
        '{OP_ENQ,  32'sh55555555, 1'b0, NO_RES},
        '{OP_ENQ,  32'shaaaaaaaa, 1'b0, NO_RES},
        '{OP_ENQ,  32'sh00000001, 1'b0, NO_RES},
        '{OP_ENQ,  32'sh7ffffffe, 1'b0, NO_RES},
        '{OP_ENQ,  32'sh0badcafe, 1'b1, '{ST_FULL, 32'sh0, 32'sh0, 1'b0, 1'b1}},
        '{OP_PEEK, 32'sh00000000, 1'b1,
          '{ST_OK, 32'sh80000000, 32'sh7ffffffe, 1'b0, 1'b1}},
        '{OP_NOP,  32'shffffffff, 1'b1, '{ST_OK, 32'sh0, 32'sh0, 1'b0, 1'b1}},
        '{OP_DEQ,  32'sh00000000, 1'b0, NO_RES},
        '{OP_DEQ,  32'sh00000000, 1'b0, NO_RES},
        '{OP_DEQ,  32'sh00000000, 1'b0, NO_RES},
        '{OP_DEQ,  32'sh00000000, 1'b0, NO_RES},
        '{OP_DEQ,  32'sh00000000, 1'b0, NO_RES},
        '{OP_DEQ,  32'sh00000000, 1'b0, NO_RES},
        '{OP_DEQ,  32'sh00000000, 1'b0, NO_RES},
        '{OP_DEQ,  32'sh00000000, 1'b0, NO_RES},
        '{OP_DEQ,  32'sh00000000, 1'b1, '{ST_EMPTY, 32'sh0, 32'sh0, 1'b1, 1'b0}},
        '{OP_ENQ,  32'sh00c0ffee, 1'b0, NO_RES}
    };

    function automatic logic [IDX_W-1:0] ring_next(logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic ring_full();
        return !ring_empty && (ring_next(ring_tail) == ring_head);
    endfunction

    function automatic queue_result_t predict_queue_op(t_opcode op, t_word value);
        queue_result_t res;
        res = '0;
        res.status = ST_OK;
        op_counts[op]++;
        case (op)
            OP_ENQ: begin
                if (ring_empty) begin
                    ring_head = '0;
                    ring_tail = '0;
                    ring_slots[0] = value;
                    ring_empty = 1'b0;
                end else if (ring_full()) begin
                    res.status = ST_FULL;
                    full_drops++;
                end else begin
                    ring_tail = ring_next(ring_tail);
                    ring_slots[ring_tail] = value;
                end
            end
            OP_DEQ: begin
                if (ring_empty) begin
                    res.status = ST_EMPTY;
                    empty_reads++;
                end else begin
                    res.head_value = ring_slots[ring_head];
                    if (ring_head == ring_tail) begin
                        ring_empty = 1'b1;
                    end else begin
                        ring_head = ring_next(ring_head);
                    end
                end
            end
            OP_PEEK: begin
                if (ring_empty) begin
                    res.status = ST_EMPTY;
                    empty_reads++;
                end else begin
                    res.head_value = ring_slots[ring_head];
                    res.tail_value = ring_slots[ring_tail];
                end
            end
            default: begin
            end
        endcase
        res.now_empty = ring_empty;
        res.now_full = ring_full();
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || hold_out) begin
            return 0;
        end
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_opcode pick_opcode(traffic_mode_t mode);
        int r;
        int enq_pct;
        int deq_pct;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                enq_pct = 70;
                deq_pct = 15;
            end
            MODE_DRAIN: begin
                enq_pct = 15;
                deq_pct = 70;
            end
            default: begin
                enq_pct = 40;
                deq_pct = 40;
            end
        endcase
        if (r < enq_pct) begin
            return OP_ENQ;
        end else if (r < enq_pct + deq_pct) begin
            return OP_DEQ;
        end else if (r < 95) begin
            return OP_PEEK;
        end
        return OP_NOP;
    endfunction

    function automatic t_word pick_value();
        case ($urandom_range(0, 15))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return -32'sd1;
            3: return 32'sh0;
            default: return t_word'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    task automatic send_word(t_opcode op, t_word value, bit typed, queue_result_t want);
        int gap;
        queue_result_t predicted;
        gap = idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.push_value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predicted = predict_queue_op(op, value);
        pending_results.push_back(typed ? want : predicted);
        accepted_count++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Long receiver hold-off so the output register stays full and stalls the sender.
    initial begin
        wait (accepted_count >= HOLD_AFTER);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    initial begin
        int stall_left;
        queue_result_t want;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                checked_count++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result status", 32'(out_ch.status), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.status !== want.status)
                        report_mismatch("status", 32'(out_ch.status), 32'(want.status));
                    if (out_ch.head_value !== want.head_value)
                        report_mismatch("head_value", out_ch.head_value, want.head_value);
                    if (out_ch.tail_value !== want.tail_value)
                        report_mismatch("tail_value", out_ch.tail_value, want.tail_value);
                    if (out_ch.now_empty !== want.now_empty)
                        report_mismatch("now_empty", 32'(out_ch.now_empty),
                                        32'(want.now_empty));
                    if (out_ch.now_full !== want.now_full)
                        report_mismatch("now_full", 32'(out_ch.now_full),
                                        32'(want.now_full));
                end
            end
            if (hold_out) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    initial begin
        int phase_left;
        traffic_mode_t mode;
        phase_left = 0;
        mode = MODE_MIX;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_NOP;
        in_ch.push_value = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].op, directed_rows[k].value,
                      directed_rows[k].typed, directed_rows[k].want);
        end

        // Phases lean toward filling or draining so full and empty are hit often.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                mode = traffic_mode_t'($urandom_range(0, 2));
                phase_left = $urandom_range(20, 90);
                calm <= ($urandom_range(0, 4) == 0);
            end
            phase_left--;
            send_word(pick_opcode(mode), pick_value(), 1'b0, NO_RES);
        end
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results missing", 32'(pending_results.size()), 0);

        $display("Ran %0d words: %0d enqueue, %0d dequeue, %0d peek, %0d no-op.",
                 accepted_count, op_counts[OP_ENQ], op_counts[OP_DEQ],
                 op_counts[OP_PEEK], op_counts[OP_NOP]);
        $display("Checked %0d results, %0d full drops, %0d empty reads, %0d errors.",
                 checked_count, full_drops, empty_reads, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
